FILE: hw/rtl/ctc_pkg.sv
// Shared types and constants for the color threshold centroid block.
package ctc_pkg;

  // Pixel and result field widths.
  localparam int PIX_W      = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_W      = 11;
  localparam int OUT_DATA_W = 24;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int IMG_W_W    = 12;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_C0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_C1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_C2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd5;

  // Register reset values.
  localparam logic [PIX_W-1:0]   RST_DEVIATION   = 8'd16;
  localparam logic [PIX_W-1:0]   RST_SAMPLE_STEP = 8'd1;
  localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH = 12'd640;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // take the pixel word on the input
    logic div_load;  // copy accumulators into the divider and clear them
    logic div_step;  // one quotient bit of both divisions
    logic out_load;  // capture the centroid into the output register
    logic mod_load;  // start recomputing the sampling phases
    logic mod_step;  // one remainder bit of both phase divisions
    logic mod_last;  // final phase step, write the phases back
  } ctc_cmd_t;

endpackage

FILE: hw/rtl/ctc_ctrl.sv
// Controller state machine: pixel acceptance, frame-end division and phase recompute.
module ctc_ctrl #(
  parameter int ITER_W = 11
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tlast,
  output logic                           in_tready,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_wr_en,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]  cfg_index,
  output ctc_pkg::ctc_cmd_t              cmd
);

  localparam int CNT_CW = $clog2(ITER_W + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;
  localparam logic [2:0] ST_MOD  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_CW-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              step_wr;
  logic              accept;

  // A sample step write in idle starts the phase recompute and holds off pixels.
  assign step_wr   = cfg_wr_en && (cfg_index == ctc_pkg::CFG_SAMPLE_STEP);
  assign in_tready = (state_r == ST_IDLE) && !step_wr;
  assign accept    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (step_wr) begin
          cmd.mod_load = 1'b1;
          cnt_nxt      = CNT_CW'(ITER_W - 1);
          state_nxt    = ST_MOD;
        end else if (accept) begin
          cmd.accept = 1'b1;
          if (in_tlast) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = CNT_CW'(ITER_W - 1);
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - CNT_CW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (cnt_r == '0) begin
          cmd.mod_last = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r - CNT_CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/ctc_datapath.sv
// Datapath: configuration registers, position tracking, accumulators and dividers.
module ctc_datapath #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ctc_pkg::ctc_cmd_t               cmd,
  input  logic [ctc_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tlast,
  input  logic                            cfg_wr_en,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic [ctc_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int PW     = ctc_pkg::PIX_W;
  localparam int OW     = ctc_pkg::OUT_W;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ITER_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SUMX_W = COL_W + CNT_W;
  localparam int SUMY_W = ROW_W + CNT_W;
  localparam int EW     = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W  = (EW > ctc_pkg::IMG_W_W) ? EW : ctc_pkg::IMG_W_W;
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_WIDTH * MAX_HEIGHT);

  // Configuration registers.
  logic [PW-1:0]                  tgt0_r, tgt1_r, tgt2_r, dev_r, step_r;
  logic [ctc_pkg::IMG_W_W-1:0]    width_r;

  // Position, sampling phases and accumulators.
  logic [COL_W-1:0]  column_r;
  logic [ROW_W-1:0]  row_r;
  logic [PW-1:0]     col_ph_r, row_ph_r;
  logic [SUMX_W-1:0] sumx_r;
  logic [SUMY_W-1:0] sumy_r;
  logic [CNT_W-1:0]  count_r;

  // Divider and phase recompute state.
  logic [ITER_W-1:0] qx_r, qy_r;
  logic [CNT_W-1:0]  rx_r, ry_r, dcnt_r;
  logic [ITER_W-1:0] mx_r, my_r;
  logic [PW-1:0]     mrx_r, mry_r;
  logic [OW-1:0]     out_x_r, out_y_r;

  // Configuration write decode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt0_r  <= '0;
      tgt1_r  <= '0;
      tgt2_r  <= '0;
      dev_r   <= ctc_pkg::RST_DEVIATION;
      step_r  <= ctc_pkg::RST_SAMPLE_STEP;
      width_r <= ctc_pkg::RST_IMAGE_WIDTH;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ctc_pkg::CFG_TARGET_C0:   tgt0_r  <= cfg_wdata[PW-1:0];
        ctc_pkg::CFG_TARGET_C1:   tgt1_r  <= cfg_wdata[PW-1:0];
        ctc_pkg::CFG_TARGET_C2:   tgt2_r  <= cfg_wdata[PW-1:0];
        ctc_pkg::CFG_DEVIATION:   dev_r   <= cfg_wdata[PW-1:0];
        ctc_pkg::CFG_SAMPLE_STEP: step_r  <= cfg_wdata[PW-1:0];
        ctc_pkg::CFG_IMAGE_WIDTH: width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Open window test of one byte around its target.
  function automatic logic in_window(input logic [7:0] v, input logic [7:0] t,
                                     input logic [7:0] d);
    logic [8:0] lo;
    logic [8:0] hi;
    lo = (t > d) ? {1'b0, t - d} : 9'd0;
    hi = {1'b0, t} + {1'b0, d};
    return ({1'b0, v} < hi) && ({1'b0, v} > lo);
  endfunction

  logic             hit, sampled, do_add;
  logic [CMP_W-1:0] wid_ext, wid_eff, col_p1;
  logic             col_wrap, row_inc;
  logic [PW:0]      cph_p1, rph_p1;
  logic [PW-1:0]    cph_inc, rph_inc;

  assign hit = in_window(in_tdata[7:0], tgt2_r, dev_r)
            && in_window(in_tdata[15:8], tgt1_r, dev_r)
            && in_window(in_tdata[23:16], tgt0_r, dev_r);
  assign sampled = (step_r != '0) && (col_ph_r == '0) && (row_ph_r == '0);
  assign do_add  = sampled && hit && (count_r < CNT_CAP);

  // Effective width: zero acts as one, large values clamp to the maximum.
  assign wid_ext  = CMP_W'(width_r);
  assign wid_eff  = (width_r == '0) ? CMP_W'(1) :
                    ((wid_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : wid_ext);
  assign col_p1   = CMP_W'(column_r) + CMP_W'(1);
  assign col_wrap = col_p1 >= wid_eff;
  assign row_inc  = row_r < ROW_W'(MAX_HEIGHT - 1);

  // Phases track column and row modulo the sample step.
  assign cph_p1  = {1'b0, col_ph_r} + (PW+1)'(1);
  assign rph_p1  = {1'b0, row_ph_r} + (PW+1)'(1);
  assign cph_inc = (cph_p1 == {1'b0, step_r}) ? '0 : cph_p1[PW-1:0];
  assign rph_inc = (rph_p1 == {1'b0, step_r}) ? '0 : rph_p1[PW-1:0];

  // Restoring division steps for the centroid.
  logic [CNT_W:0] tx, ty;
  logic           gex, gey;
  assign tx  = {rx_r, qx_r[ITER_W-1]};
  assign ty  = {ry_r, qy_r[ITER_W-1]};
  assign gex = tx >= {1'b0, dcnt_r};
  assign gey = ty >= {1'b0, dcnt_r};

  // Remainder steps for the phase recompute.
  logic [PW:0]   tmx, tmy;
  logic          gmx, gmy;
  logic [PW-1:0] mrx_nxt, mry_nxt;
  assign tmx     = {mrx_r, mx_r[ITER_W-1]};
  assign tmy     = {mry_r, my_r[ITER_W-1]};
  assign gmx     = tmx >= {1'b0, step_r};
  assign gmy     = tmy >= {1'b0, step_r};
  assign mrx_nxt = gmx ? PW'(tmx - {1'b0, step_r}) : PW'(tmx);
  assign mry_nxt = gmy ? PW'(tmy - {1'b0, step_r}) : PW'(tmy);

  // Pixel path: accumulate, advance or clear position, clear sums, write back phases.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
      col_ph_r <= '0;
      row_ph_r <= '0;
      sumx_r   <= '0;
      sumy_r   <= '0;
      count_r  <= '0;
    end else if (cmd.accept) begin
      if (do_add) begin
        sumx_r  <= sumx_r + SUMX_W'(column_r);
        sumy_r  <= sumy_r + SUMY_W'(row_r);
        count_r <= count_r + CNT_W'(1);
      end
      if (in_tlast) begin
        column_r <= '0;
        row_r    <= '0;
        col_ph_r <= '0;
        row_ph_r <= '0;
      end else if (col_wrap) begin
        column_r <= '0;
        col_ph_r <= '0;
        if (row_inc) begin
          row_r    <= row_r + ROW_W'(1);
          row_ph_r <= rph_inc;
        end
      end else begin
        column_r <= column_r + COL_W'(1);
        col_ph_r <= cph_inc;
      end
    end else if (cmd.div_load) begin
      sumx_r  <= '0;
      sumy_r  <= '0;
      count_r <= '0;
    end else if (cmd.mod_last) begin
      col_ph_r <= mrx_nxt;
      row_ph_r <= mry_nxt;
    end
  end

  // Divider: the quotient fits in ITER_W bits, so the high dividend bits
  // start out as the partial remainder.
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      qx_r   <= sumx_r[ITER_W-1:0];
      qy_r   <= sumy_r[ITER_W-1:0];
      rx_r   <= CNT_W'(sumx_r >> ITER_W);
      ry_r   <= CNT_W'(sumy_r >> ITER_W);
      dcnt_r <= count_r;
    end else if (cmd.div_step) begin
      qx_r <= (qx_r << 1) | ITER_W'(gex);
      qy_r <= (qy_r << 1) | ITER_W'(gey);
      rx_r <= gex ? CNT_W'(tx - {1'b0, dcnt_r}) : CNT_W'(tx);
      ry_r <= gey ? CNT_W'(ty - {1'b0, dcnt_r}) : CNT_W'(ty);
    end
  end

  // Phase recompute: column and row modulo the new step, one bit a cycle.
  always_ff @(posedge clk) begin
    if (cmd.mod_load) begin
      mx_r  <= ITER_W'(column_r);
      my_r  <= ITER_W'(row_r);
      mrx_r <= '0;
      mry_r <= '0;
    end else if (cmd.mod_step) begin
      mx_r  <= mx_r << 1;
      my_r  <= my_r << 1;
      mrx_r <= mrx_nxt;
      mry_r <= mry_nxt;
    end
  end

  // Output register; an empty frame reports the origin.
  logic [ITER_W+OW-1:0] qx_ext, qy_ext;
  assign qx_ext = {{OW{1'b0}}, qx_r};
  assign qy_ext = {{OW{1'b0}}, qy_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_x_r <= (dcnt_r == '0) ? '0 : qx_ext[OW-1:0];
      out_y_r <= (dcnt_r == '0) ? '0 : qy_ext[OW-1:0];
    end
  end

  assign out_tdata = {(ctc_pkg::OUT_DATA_W - 2*OW)'(0), out_y_r, out_x_r};

endmodule

FILE: hw/rtl/color_threshold_centroid.sv
// Top level of the color threshold centroid block.
// Throughput: one pixel word per cycle within a frame, unless a sample_step write stalls input
// for its phase recompute; the frame-end word holds off input through the load, divide and
// done states, longer while an earlier result waits on out_tready. The centroid word is
// captured in the output register in the done state once the division completes.
// Synchronous reset covers control, position, sums and config, not divider or output data.
module color_threshold_centroid #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ctc_pkg::IN_DATA_W-1:0]   in_tdata,   // byte0, byte1, byte2
  input  logic                            in_tlast,   // frame_end
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ctc_pkg::OUT_DATA_W-1:0]  out_tdata,  // centroid_x, centroid_y, zero pad
  input  logic                            cfg_wr_en,
  input  logic [ctc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ITER_W = (COL_W > ROW_W) ? COL_W : ROW_W;

  ctc_pkg::ctc_cmd_t cmd;

  ctc_ctrl #(
    .ITER_W(ITER_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cmd       (cmd)
  );

  ctc_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .out_tdata(out_tdata)
  );

  // The frame-end word always starts the division, so input stalls next cycle.
  a_frame_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input not stalled after frame-end word");

  // A new result only appears right after a point at which no pixel could be taken.
  a_result_after_division: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result raised without a preceding division");

  // Commands are mutually exclusive between pixel intake and the dividers.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.accept, cmd.div_load, cmd.div_step, cmd.out_load,
                cmd.mod_load, cmd.mod_step}) <= 1)
    else $error("conflicting datapath commands");

endmodule
